@@ design/first_fit_heap_allocator_defines.svh @@
// Assertion macros shared by the checker of the first-fit heap allocator.
// Needs signals named clk and rst in the module that uses them.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define FFHA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FFHA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/ffha_pkg.sv @@
// Package for the first-fit heap allocator: default sizes, opcodes,
// status codes and sequencer states. Depends on nothing.
package ffha_pkg;

  localparam int POOL_BYTES_DEF   = 4096;
  localparam int HEADER_BYTES_DEF = 16;
  localparam int FIELD_W          = 12;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_SIZE  = 2'd1,
    ST_NO_SPACE  = 2'd2,
    ST_NOT_ALLOC = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_FETCH,
    S_CHECK,
    S_SPLIT,
    S_FETCH_N,
    S_CHECK_N,
    S_MERGE,
    S_DONE
  } state_t;

endpackage

@@ design/first_fit_heap_allocator.sv @@
// First-fit heap allocator with coalescing: header store, chain walker and
// result register. Depends on ffha_pkg.
//
//   channel | handshake           | payload
//   --------+---------------------+-----------------------------------------
//   in      | in_valid / in_ready | opcode, request_bytes, data_offset
//   out     | out_valid/out_ready | status, granted_offset
//
// A request walks the block chain from offset 0, each block visited taking
// a header read, then a check, on the single header store port, followed by
// split or merge writes and the result. A zero-size allocate goes straight
// from idle to the result. in_ready is high only between requests. After
// reset the init state writes the header at offset 0; only chain headers are
// ever read. A result not yet taken holds the walker in its last state.
module first_fit_heap_allocator #(
  parameter int POOL_BYTES   = ffha_pkg::POOL_BYTES_DEF,
  parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         opcode,
  input  logic [ffha_pkg::FIELD_W-1:0] request_bytes,
  input  logic [ffha_pkg::FIELD_W-1:0] data_offset,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   status,
  output logic [ffha_pkg::FIELD_W-1:0] granted_offset
);

  localparam int ADDR_W = $clog2(POOL_BYTES);
  localparam int WK_W   = (ADDR_W + 1 > 14) ? ADDR_W + 1 : 14;
  localparam logic [WK_W-1:0] HDR  = WK_W'(HEADER_BYTES);
  localparam logic [WK_W-1:0] POOL = WK_W'(POOL_BYTES);
  localparam logic [ADDR_W-1:0] INIT_SIZE =
    (POOL_BYTES > HEADER_BYTES) ? ADDR_W'(POOL_BYTES - HEADER_BYTES) : '0;

  typedef struct packed {
    logic              free;
    logic [ADDR_W-1:0] size;
  } hdr_t;

  ffha_pkg::state_t  state, state_next;
  ffha_pkg::status_t res_status;
  logic [ffha_pkg::FIELD_W-1:0] res_grant;

  logic            op;
  logic [WK_W-1:0] req;
  logic [WK_W-1:0] dofs;
  logic [WK_W-1:0] blk;
  logic [WK_W-1:0] prev_blk;
  hdr_t            prev_hdr;
  logic            have_prev;
  logic [WK_W-1:0] cur_blk;
  logic [ADDR_W-1:0] cur_size;

  // header store
  hdr_t mem [POOL_BYTES];
  hdr_t rd_hdr;
  logic mem_re;
  logic mem_we;
  logic [ADDR_W-1:0] mem_wa;
  hdr_t mem_wd;

  // datapath
  logic [WK_W-1:0] size_ext;
  logic [WK_W-1:0] req_h;
  logic [WK_W-1:0] nxt_blk;
  logic [WK_W-1:0] data_pos;
  logic [WK_W-1:0] rest_addr;
  logic [WK_W-1:0] rest_size;
  logic [WK_W-1:0] merge_size;
  logic [WK_W-1:0] tail_size;
  logic            fit;
  logic            hit;
  logic            at_end;
  logic            use_prev;
  logic            accept;
  logic            deliver;

  assign accept  = in_valid && in_ready;
  assign deliver = (state == ffha_pkg::S_DONE) && (!out_valid || out_ready);

  assign size_ext   = WK_W'(rd_hdr.size);
  assign req_h      = req + HDR;
  assign nxt_blk    = blk + HDR + size_ext;
  assign data_pos   = blk + HDR;
  assign rest_addr  = blk + req_h;
  assign rest_size  = size_ext - req_h;
  assign merge_size = WK_W'(prev_hdr.size) + HDR + size_ext;
  assign tail_size  = WK_W'(cur_size) + HDR + size_ext;
  assign fit        = rd_hdr.free && (size_ext > req_h);
  assign hit        = !rd_hdr.free && (data_pos == dofs);
  assign at_end     = (blk >= POOL);
  assign use_prev   = have_prev && prev_hdr.free;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_hdr <= mem[blk[ADDR_W-1:0]];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ffha_pkg::S_INIT: state_next = ffha_pkg::S_IDLE;
      ffha_pkg::S_IDLE: begin
        if (in_valid) begin
          if (opcode == ffha_pkg::OP_ALLOC && request_bytes == '0) begin
            state_next = ffha_pkg::S_DONE;
          end else begin
            state_next = ffha_pkg::S_FETCH;
          end
        end
      end
      ffha_pkg::S_FETCH: state_next = at_end ? ffha_pkg::S_DONE : ffha_pkg::S_CHECK;
      ffha_pkg::S_CHECK: begin
        if (op == ffha_pkg::OP_ALLOC) begin
          state_next = fit ? ffha_pkg::S_SPLIT : ffha_pkg::S_FETCH;
        end else if (hit) begin
          state_next = (nxt_blk < POOL) ? ffha_pkg::S_FETCH_N : ffha_pkg::S_MERGE;
        end else begin
          state_next = ffha_pkg::S_FETCH;
        end
      end
      ffha_pkg::S_SPLIT:   state_next = ffha_pkg::S_DONE;
      ffha_pkg::S_FETCH_N: state_next = ffha_pkg::S_CHECK_N;
      ffha_pkg::S_CHECK_N: state_next = ffha_pkg::S_MERGE;
      ffha_pkg::S_MERGE:   state_next = ffha_pkg::S_DONE;
      ffha_pkg::S_DONE:    state_next = deliver ? ffha_pkg::S_IDLE : ffha_pkg::S_DONE;
      default:             state_next = ffha_pkg::S_IDLE;
    endcase
  end

  // store port and handshake outputs
  always_comb begin
    in_ready = 1'b0;
    mem_re   = 1'b0;
    mem_we   = 1'b0;
    mem_wa   = blk[ADDR_W-1:0];
    mem_wd   = '{free: 1'b1, size: INIT_SIZE};
    case (state)
      ffha_pkg::S_INIT: begin
        mem_we = 1'b1;
        mem_wa = '0;
      end
      ffha_pkg::S_IDLE: in_ready = 1'b1;
      ffha_pkg::S_FETCH,
      ffha_pkg::S_FETCH_N: mem_re = 1'b1;
      ffha_pkg::S_CHECK: begin
        // remainder of a split block becomes a new free block
        if (op == ffha_pkg::OP_ALLOC && fit) begin
          mem_we = 1'b1;
          mem_wa = rest_addr[ADDR_W-1:0];
          mem_wd = '{free: 1'b1, size: rest_size[ADDR_W-1:0]};
        end
      end
      ffha_pkg::S_SPLIT: begin
        mem_we = 1'b1;
        mem_wd = '{free: 1'b0, size: req[ADDR_W-1:0]};
      end
      ffha_pkg::S_MERGE: begin
        mem_we = 1'b1;
        mem_wa = cur_blk[ADDR_W-1:0];
        mem_wd = '{free: 1'b1, size: cur_size};
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ffha_pkg::S_INIT;
      out_valid <= 1'b0;
      have_prev <= 1'b0;
    end else begin
      state <= state_next;
      if (deliver) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        have_prev <= 1'b0;
      end else if (state == ffha_pkg::S_CHECK) begin
        have_prev <= 1'b1;
      end
    end
  end

  // walker and result payload
  always_ff @(posedge clk) begin
    case (state)
      ffha_pkg::S_IDLE: begin
        op         <= opcode;
        req        <= WK_W'(request_bytes);
        dofs       <= WK_W'(data_offset);
        blk        <= '0;
        res_status <= ffha_pkg::ST_BAD_SIZE;
        res_grant  <= '0;
      end
      ffha_pkg::S_FETCH: begin
        if (at_end) begin
          res_status <= (op == ffha_pkg::OP_ALLOC) ? ffha_pkg::ST_NO_SPACE
                                                   : ffha_pkg::ST_NOT_ALLOC;
          res_grant  <= '0;
        end
      end
      ffha_pkg::S_CHECK: begin
        prev_blk <= blk;
        prev_hdr <= rd_hdr;
        if (op == ffha_pkg::OP_ALLOC && fit) begin
          res_status <= ffha_pkg::ST_OK;
          res_grant  <= data_pos[ffha_pkg::FIELD_W-1:0];
        end else begin
          blk <= nxt_blk;
          if (op == ffha_pkg::OP_FREE && hit) begin
            // fold into a free predecessor, if there is one
            cur_blk    <= use_prev ? prev_blk : blk;
            cur_size   <= use_prev ? merge_size[ADDR_W-1:0] : rd_hdr.size;
            res_status <= ffha_pkg::ST_OK;
            res_grant  <= '0;
          end
        end
      end
      ffha_pkg::S_CHECK_N: begin
        if (rd_hdr.free) begin
          cur_size <= tail_size[ADDR_W-1:0];
        end
      end
      ffha_pkg::S_DONE: begin
        if (deliver) begin
          status         <= res_status;
          granted_offset <= res_grant;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ design/ffha_checker.sv @@
// Port checker for the first-fit heap allocator, bound to the top level.
// Depends on ffha_pkg and first_fit_heap_allocator_defines.svh.
`include "first_fit_heap_allocator_defines.svh"

module ffha_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [1:0]                   status,
  input logic [ffha_pkg::FIELD_W-1:0] granted_offset
);

  `FFHA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(status) && $stable(granted_offset), "result dropped while stalled")

  `FFHA_ASSERT_NOW(a_fail_zero, out_valid && status != ffha_pkg::ST_OK,
    granted_offset == '0, "failed request shows a nonzero offset")

  `FFHA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready,
    !in_ready, "request accepted while a walk is running")

  `FFHA_ASSERT_NOW(a_result_from_busy, $rose(out_valid),
    !$past(in_ready), "result appeared without a request in progress")

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .status         (status),
  .granted_offset (granted_offset)
);

@@ sim/testbench.sv @@
// Self-checking testbench for the first-fit heap allocator: directed and random
// allocate/free requests, checked against a behavioural image of the block chain.
// Depends on ffha_pkg and first_fit_heap_allocator.
module testbench;

  localparam int unsigned POOL  = ffha_pkg::POOL_BYTES_DEF;
  localparam int unsigned HDR   = ffha_pkg::HEADER_BYTES_DEF;
  localparam int FIELD_W        = ffha_pkg::FIELD_W;
  localparam int QUIET_LIMIT    = 4000;
  localparam int DRAIN_CYCLES   = 2 * POOL / (HDR + 1) + 8;
  localparam int RANDOM_ITEMS   = 1000;

  typedef struct packed {
    ffha_pkg::status_t    st;
    logic [FIELD_W-1:0]   ofs;
  } outcome_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               opcode = ffha_pkg::OP_ALLOC;
  logic [FIELD_W-1:0] request_bytes = '0;
  logic [FIELD_W-1:0] data_offset = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         status;
  logic [FIELD_W-1:0] granted_offset;

  // heap image: size and free mark per byte offset, only chain starts matter
  int unsigned        hdr_size [POOL];
  bit                 hdr_free [POOL];

  outcome_t           pending_outcomes [$];
  logic [FIELD_W-1:0] live_blocks [$];
  logic [FIELD_W-1:0] last_released = '0;
  outcome_t           oldest;

  int mismatches = 0;
  int results_seen = 0;
  int tally [2][4];
  int merges_back = 0;
  int merges_fwd = 0;
  int burst_left = 0;
  int quiet_cycles = 0;
  int ready_mode = 0;
  int ready_run = 0;

  first_fit_heap_allocator dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .request_bytes  (request_bytes),
    .data_offset    (data_offset),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .granted_offset (granted_offset)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void clear_heap_image();
    foreach (hdr_size[i]) begin
      hdr_size[i] = 0;
      hdr_free[i] = 1'b0;
    end
    hdr_size[0] = POOL - HDR;
    hdr_free[0] = 1'b1;
  endfunction

  function automatic outcome_t predict_alloc(int unsigned req);
    int unsigned pos;
    int unsigned rest;
    outcome_t    res;
    res.st  = ffha_pkg::ST_NO_SPACE;
    res.ofs = '0;
    if (req == 0) begin
      res.st = ffha_pkg::ST_BAD_SIZE;
      return res;
    end
    pos = 0;
    while (pos < POOL) begin
      // strict fit: the remainder must keep a header and at least one byte
      if (hdr_free[pos] && hdr_size[pos] > req + HDR) begin
        rest = pos + HDR + req;
        if (rest < POOL) begin
          hdr_size[rest] = hdr_size[pos] - HDR - req;
          hdr_free[rest] = 1'b1;
        end
        hdr_size[pos] = req;
        hdr_free[pos] = 1'b0;
        res.st  = ffha_pkg::ST_OK;
        res.ofs = FIELD_W'(pos + HDR);
        return res;
      end
      pos = pos + HDR + hdr_size[pos];
    end
    return res;
  endfunction

  function automatic outcome_t predict_free(int unsigned dofs);
    int unsigned pos;
    int unsigned prev;
    int unsigned cur;
    int unsigned nxt;
    bit          has_prev;
    outcome_t    res;
    res.st   = ffha_pkg::ST_NOT_ALLOC;
    res.ofs  = '0;
    pos      = 0;
    prev     = 0;
    has_prev = 1'b0;
    while (pos < POOL) begin
      if (!hdr_free[pos] && pos + HDR == dofs) begin
        cur = pos;
        if (has_prev && hdr_free[prev]) begin
          hdr_size[prev] += HDR + hdr_size[pos];
          cur = prev;
          merges_back++;
        end
        nxt = cur + HDR + hdr_size[cur];
        if (nxt < POOL && hdr_free[nxt]) begin
          hdr_size[cur] += HDR + hdr_size[nxt];
          merges_fwd++;
        end
        hdr_free[cur] = 1'b1;
        res.st = ffha_pkg::ST_OK;
        return res;
      end
      prev     = pos;
      has_prev = 1'b1;
      pos      = pos + HDR + hdr_size[pos];
    end
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // one request: optional idle gap, handshake, then the heap image is updated
  task automatic send_request(input logic op, input logic [FIELD_W-1:0] req_b,
                              input logic [FIELD_W-1:0] ofs);
    outcome_t outcome;
    int       idx;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
    in_valid      <= 1'b1;
    opcode        <= op;
    request_bytes <= req_b;
    data_offset   <= ofs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);

    if (op == ffha_pkg::OP_ALLOC) outcome = predict_alloc(req_b);
    else outcome = predict_free(ofs);
    pending_outcomes.push_back(outcome);
    tally[op][outcome.st]++;

    if (op == ffha_pkg::OP_ALLOC && outcome.st == ffha_pkg::ST_OK) begin
      live_blocks.push_back(outcome.ofs);
    end else if (op == ffha_pkg::OP_FREE && outcome.st == ffha_pkg::ST_OK) begin
      idx = -1;
      foreach (live_blocks[i]) if (live_blocks[i] == ofs) idx = i;
      if (idx >= 0) live_blocks.delete(idx);
      last_released = ofs;
    end
  endtask

  // zero, oversize, exact-size (strict fit), frees of offsets never granted and a double free
  task automatic test_size_limits();
    send_request(ffha_pkg::OP_ALLOC, 12'd0, 12'hFFF);
    send_request(ffha_pkg::OP_ALLOC, 12'hFFF, 12'd0);
    send_request(ffha_pkg::OP_ALLOC, FIELD_W'(POOL - 2 * HDR), 12'h555);
    send_request(ffha_pkg::OP_FREE, 12'hAAA, FIELD_W'(HDR));
    send_request(ffha_pkg::OP_FREE, 12'd0, 12'd0);
    send_request(ffha_pkg::OP_FREE, 12'hFFF, 12'hFFF);
    // largest request that fits leaves a one-byte remainder
    send_request(ffha_pkg::OP_ALLOC, FIELD_W'(POOL - 2 * HDR - 1), 12'd0);
    send_request(ffha_pkg::OP_ALLOC, 12'd1, 12'd0);
    send_request(ffha_pkg::OP_FREE, 12'd0, FIELD_W'(HDR));
    send_request(ffha_pkg::OP_FREE, 12'd0, FIELD_W'(HDR));
  endtask

  // release with no free neighbour, with one behind, one ahead, and both
  task automatic test_coalescing();
    logic [FIELD_W-1:0] blk_a;
    logic [FIELD_W-1:0] blk_b;
    logic [FIELD_W-1:0] blk_c;
    logic [FIELD_W-1:0] blk_d;
    blk_a = FIELD_W'(HDR);
    blk_b = FIELD_W'(blk_a + 100 + HDR);
    blk_c = FIELD_W'(blk_b + 200 + HDR);
    blk_d = FIELD_W'(blk_c + 300 + HDR);
    send_request(ffha_pkg::OP_ALLOC, 12'd100, 12'd0);
    send_request(ffha_pkg::OP_ALLOC, 12'd200, 12'd0);
    send_request(ffha_pkg::OP_ALLOC, 12'd300, 12'd0);
    send_request(ffha_pkg::OP_ALLOC, 12'd50, 12'd0);
    send_request(ffha_pkg::OP_FREE, 12'd0, blk_a + 12'd1);
    send_request(ffha_pkg::OP_FREE, 12'd0, blk_b);
    send_request(ffha_pkg::OP_FREE, 12'd0, blk_b);
    send_request(ffha_pkg::OP_FREE, 12'd0, blk_c);
    send_request(ffha_pkg::OP_FREE, 12'd0, blk_a);
    send_request(ffha_pkg::OP_FREE, 12'd0, blk_d);
  endtask

  // mostly well-formed alloc/free traffic on live blocks, some junk mixed in
  task automatic test_random_traffic();
    int                 pick;
    logic [FIELD_W-1:0] junk;
    logic [FIELD_W-1:0] target;
    repeat (RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      junk = FIELD_W'($urandom_range(0, 4095));
      if (pick < 40) begin
        send_request(ffha_pkg::OP_ALLOC, FIELD_W'($urandom_range(1, 48)), junk);
      end else if (pick < 48) begin
        send_request(ffha_pkg::OP_ALLOC, FIELD_W'($urandom_range(49, 700)), junk);
      end else if (pick < 51) begin
        send_request(ffha_pkg::OP_ALLOC, FIELD_W'($urandom_range(0, 4095)), junk);
      end else if (pick < 53) begin
        send_request(ffha_pkg::OP_ALLOC, '0, junk);
      end else if (pick < 85 || live_blocks.size() == 0) begin
        if (live_blocks.size() == 0) begin
          send_request(ffha_pkg::OP_ALLOC, FIELD_W'($urandom_range(1, 64)), junk);
        end else begin
          target = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
          send_request(ffha_pkg::OP_FREE, junk, target);
        end
      end else if (pick < 90) begin
        send_request(ffha_pkg::OP_FREE, junk, FIELD_W'($urandom_range(0, 4095)));
      end else if (pick < 95) begin
        send_request(ffha_pkg::OP_FREE, junk, last_released);
      end else begin
        // header or interior of a live block
        target = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
        if ($urandom_range(0, 1) == 1) target = target + FIELD_W'($urandom_range(1, HDR));
        else target = target - FIELD_W'($urandom_range(1, HDR));
        send_request(ffha_pkg::OP_FREE, junk, target);
      end
    end
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // receiver: runs of always-ready, random, sparse and toggling acceptance
  always @(posedge clk) begin
    if (ready_run == 0) begin
      ready_mode <= $urandom_range(0, 3);
      ready_run  <= $urandom_range(8, 64);
    end else begin
      ready_run <= ready_run - 1;
    end
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= ~out_ready;
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_outcomes.size() == 0) begin
        report_mismatch($sformatf("result status=%0d offset=%0d with no request pending",
                                  status, granted_offset));
      end else begin
        oldest = pending_outcomes.pop_front();
        if (status !== oldest.st)
          report_mismatch($sformatf("result %0d: status %0d, expected %s",
                                    results_seen, status, oldest.st.name()));
        if (granted_offset !== oldest.ofs)
          report_mismatch($sformatf("result %0d: granted_offset %0d, expected %0d",
                                    results_seen, granted_offset, oldest.ofs));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: nothing moved for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, pending_outcomes.size());
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    foreach (tally[i, j]) tally[i][j] = 0;
    clear_heap_image();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_size_limits();
    test_coalescing();
    test_random_traffic();
    wait_for_drain();

    if (pending_outcomes.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_outcomes.size()));

    $display("Checked %0d results: allocations %0d granted, %0d no space, %0d zero size",
             results_seen, tally[ffha_pkg::OP_ALLOC][ffha_pkg::ST_OK],
             tally[ffha_pkg::OP_ALLOC][ffha_pkg::ST_NO_SPACE],
             tally[ffha_pkg::OP_ALLOC][ffha_pkg::ST_BAD_SIZE]);
    $display("Releases %0d done (%0d merged backward, %0d forward), %0d refused",
             tally[ffha_pkg::OP_FREE][ffha_pkg::ST_OK], merges_back, merges_fwd,
             tally[ffha_pkg::OP_FREE][ffha_pkg::ST_NOT_ALLOC]);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/ffha_pkg.sv
design/first_fit_heap_allocator.sv
design/ffha_checker.sv
sim/testbench.sv
